// File: hdl/fisr_pkg.sv
package fisr_pkg;

	// Seed constant of the integer first guess.
	localparam logic [31:0] MAGIC_SEED = 32'h5f3759df;
	// Canonical quiet NaN pattern.
	localparam logic [31:0] CANON_NAN  = 32'h7fc00000;
	// Single-precision 0.5 and 1.5.
	localparam logic [31:0] HALF_BITS  = 32'h3f000000;
	localparam logic [31:0] ONE_P5     = 32'h3fc00000;
	// Stage count of one multiply or subtract unit.
	localparam int          OP_LAT     = 2;
	// Stage count of one Newton step: three multiplies and a subtract.
	localparam int          STEP_LAT   = 4 * OP_LAT;

	// Leading zero count of a 48-bit word (48 when the word is zero).
	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	// Leading zero count of a 28-bit word (28 when the word is zero).
	function automatic logic [4:0] lzc28(input logic [27:0] v);
		logic [4:0] n;
		n = 5'd28;
		for (int i = 0; i < 28; i++) begin
			if (v[i]) n = 5'(27 - i);
		end
		return n;
	endfunction

	// Round to nearest even and pack. The exponent field minus one is added to the
	// 24-bit significand, so the hidden bit and any rounding carry land in the exponent.
	function automatic logic [31:0] round_pack(input logic sgn, input logic [9:0] base,
			input logic [23:0] man, input logic grd, input logic stk);
		logic        inc;
		logic [33:0] total;
		inc   = grd & (stk | man[0]);
		total = {1'b0, base, 23'b0} + {10'b0, man} + {33'b0, inc};
		if (total[33:23] >= 11'd255)
			return {sgn, 8'hff, 23'b0};
		return {sgn, total[30:0]};
	endfunction

endpackage

// File: hdl/fisr_in_if.sv
interface fisr_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] value_bits;

	modport source (output valid, output value_bits, input ready);
	modport sink   (input valid, input value_bits, output ready);
endinterface

// File: hdl/fisr_out_if.sv
interface fisr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_bits;

	modport source (output valid, output result_bits, input ready);
	modport sink   (input valid, input result_bits, output ready);
endinterface

// File: hdl/fisr_fmul.sv
module fisr_fmul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p
);
	import fisr_pkg::*;

	logic [7:0]  ea, eb, eae, ebe;
	logic [23:0] ma, mb;
	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

	logic [47:0] prod_s1;
	logic [8:0]  esum_s1;
	logic        sign_s1, nan_s1, inf_s1, zero_s1;

	logic [5:0]         lz;
	logic signed [10:0] e_n;
	logic [10:0]        shr;
	logic [47:0]        norm, wide;
	logic               ext;
	logic [9:0]         base;

	// Unpack the operands; a subnormal takes exponent one and no hidden bit.
	always_comb begin
		ea     = a[30:23];
		eb     = b[30:23];
		eae    = (ea == 8'd0) ? 8'd1 : ea;
		ebe    = (eb == 8'd0) ? 8'd1 : eb;
		ma     = {(ea != 8'd0), a[22:0]};
		mb     = {(eb != 8'd0), b[22:0]};
		nan_a  = (ea == 8'hff) && (a[22:0] != 23'd0);
		nan_b  = (eb == 8'hff) && (b[22:0] != 23'd0);
		inf_a  = (ea == 8'hff) && (a[22:0] == 23'd0);
		inf_b  = (eb == 8'hff) && (b[22:0] == 23'd0);
		zero_a = (ea == 8'd0) && (a[22:0] == 23'd0);
		zero_b = (eb == 8'd0) && (b[22:0] == 23'd0);
	end

	// First stage: significand product and exponent sum.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ma * mb;
			esum_s1 <= {1'b0, eae} + {1'b0, ebe};
			sign_s1 <= a[31] ^ b[31];
			nan_s1  <= nan_a | nan_b | (inf_a & zero_b) | (inf_b & zero_a);
			inf_s1  <= inf_a | inf_b;
			zero_s1 <= zero_a | zero_b;
		end
	end

	// Normalize the product, denormalize when the exponent falls below one.
	always_comb begin
		lz   = lzc48(prod_s1);
		e_n  = $signed({2'b0, esum_s1}) - $signed({5'b0, lz}) - 11'sd126;
		norm = prod_s1 << lz;
		shr  = 11'(11'sd1 - e_n);
		ext  = 1'b0;
		if (e_n >= 11'sd1) begin
			base = 10'(e_n - 11'sd1);
			wide = norm;
		end else begin
			base = 10'd0;
			if (shr >= 11'd48) begin
				wide = 48'd0;
				ext  = |norm;
			end else begin
				wide = norm >> shr[5:0];
				ext  = |(norm & ~({48{1'b1}} << shr[5:0]));
			end
		end
	end

	// Second stage: special cases and rounding.
	always_ff @(posedge clk) begin
		if (en) begin
			if (nan_s1)
				p <= CANON_NAN;
			else if (inf_s1)
				p <= {sign_s1, 8'hff, 23'b0};
			else if (zero_s1)
				p <= {sign_s1, 31'b0};
			else
				p <= round_pack(sign_s1, base, wide[47:24], wide[23], (|wide[22:0]) | ext);
		end
	end
endmodule

// File: hdl/fisr_fsub.sv
module fisr_fsub (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] b,
	output logic [31:0] r
);
	import fisr_pkg::*;

	logic [31:0] bn, big, sml;
	logic [7:0]  e_big, e_sml, d;
	logic [26:0] m_big, m_sml, sm, m_al;
	logic        stk;

	logic [27:0] sum_s1;
	logic [7:0]  ebig_s1;
	logic        sign_s1, nan_s1, inf_s1, isign_s1;

	logic [4:0]  lz;
	logic [4:0]  sl;
	logic [27:0] s2;
	logic [23:0] man;
	logic        grd, stk2;
	logic [9:0]  base;

	// Align 1.5 and the negated operand; the larger magnitude leads.
	always_comb begin
		bn = {~b[31], b[30:0]};
		if (ONE_P5[30:0] >= bn[30:0]) begin
			big = ONE_P5;
			sml = bn;
		end else begin
			big = bn;
			sml = ONE_P5;
		end
		e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		m_big = {(big[30:23] != 8'd0), big[22:0], 3'b0};
		m_sml = {(sml[30:23] != 8'd0), sml[22:0], 3'b0};
		d     = e_big - e_sml;
		if (d >= 8'd27) begin
			sm  = 27'd0;
			stk = |m_sml;
		end else begin
			sm  = m_sml >> d[4:0];
			stk = |(m_sml & ~({27{1'b1}} << d[4:0]));
		end
		m_al = {sm[26:1], sm[0] | stk};
	end

	// First stage: aligned add or subtract.
	always_ff @(posedge clk) begin
		if (en) begin
			if (big[31] != sml[31])
				sum_s1 <= {1'b0, m_big} - {1'b0, m_al};
			else
				sum_s1 <= {1'b0, m_big} + {1'b0, m_al};
			ebig_s1  <= e_big;
			sign_s1  <= big[31];
			nan_s1   <= (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
			inf_s1   <= (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
			isign_s1 <= bn[31];
		end
	end

	// Normalize the sum; a carry shifts right, a cancellation shifts left.
	always_comb begin
		lz   = lzc28(sum_s1);
		sl   = 5'd0;
		s2   = sum_s1;
		man  = sum_s1[27:4];
		grd  = sum_s1[3];
		stk2 = |sum_s1[2:0];
		base = {2'b0, ebig_s1};
		if (!sum_s1[27]) begin
			if ({3'b0, lz} <= ebig_s1) begin
				sl   = 5'(lz - 5'd1);
				base = 10'({2'b0, ebig_s1} - {5'b0, lz});
			end else begin
				sl   = 5'(ebig_s1 - 8'd1);
				base = 10'd0;
			end
			s2   = sum_s1 << sl;
			man  = s2[26:3];
			grd  = s2[2];
			stk2 = |s2[1:0];
		end
	end

	// Second stage: special cases and rounding.
	always_ff @(posedge clk) begin
		if (en) begin
			if (nan_s1)
				r <= CANON_NAN;
			else if (inf_s1)
				r <= {isign_s1, 8'hff, 23'b0};
			else if (sum_s1 == 28'd0)
				r <= 32'd0;
			else
				r <= round_pack(sign_s1, base, man, grd, stk2);
		end
	end
endmodule

// File: hdl/fisr_step.sv
module fisr_step (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] h_in,
	input  logic [31:0] y_in,
	output logic [31:0] h_out,
	output logic [31:0] y_out
);
	import fisr_pkg::*;

	logic [31:0] h_dly [STEP_LAT];
	logic [31:0] y_dly [3 * OP_LAT];
	logic [31:0] t1, t2, t3;

	// Delay lines keep h and y aligned with the operation chain.
	always_ff @(posedge clk) begin
		if (en) begin
			h_dly[0] <= h_in;
			for (int i = 1; i < STEP_LAT; i++) h_dly[i] <= h_dly[i-1];
			y_dly[0] <= y_in;
			for (int i = 1; i < 3 * OP_LAT; i++) y_dly[i] <= y_dly[i-1];
		end
	end

	assign h_out = h_dly[STEP_LAT-1];

	// One Newton step: y * (1.5 - (h * y) * y).
	fisr_fmul u_mul1 (.clk(clk), .en(en), .a(h_in), .b(y_in), .p(t1));
	fisr_fmul u_mul2 (.clk(clk), .en(en), .a(t1), .b(y_dly[OP_LAT-1]), .p(t2));
	fisr_fsub u_sub  (.clk(clk), .en(en), .b(t2), .r(t3));
	fisr_fmul u_mul3 (.clk(clk), .en(en), .a(y_dly[3*OP_LAT-1]), .b(t3), .p(y_out));
endmodule

// File: hdl/fast_inverse_sqrt_float32.sv
// An accepted operand runs through the x * 0.5 multiply and the seed delay side by side,
// then through NEWTON_STEPS Newton steps (one by default) to its result word.
// Throughput: one word per cycle except while stalled: the whole pipeline holds while a
// finished result word waits for ready. Each multiply and subtract unit is two stages deep.
// Reset (arst_n low, asynchronous) clears the valid bits only; data registers are not reset.
module fast_inverse_sqrt_float32 #(
	parameter int NEWTON_STEPS = 1
) (
	input  logic        clk,
	input  logic        arst_n,
	fisr_in_if.sink     operand,
	fisr_out_if.source  result
);
	import fisr_pkg::*;

	localparam int VLEN = OP_LAT + STEP_LAT * NEWTON_STEPS;

	logic            en;
	logic [VLEN-1:0] vld_q;
	logic [31:0]     seed;
	logic [31:0]     seed_s1, seed_s2;
	logic [31:0]     h_chain [NEWTON_STEPS+1];
	logic [31:0]     y_chain [NEWTON_STEPS+1];

	// Advance when the output stage is empty or being taken.
	assign en            = !vld_q[VLEN-1] || result.ready;
	assign operand.ready = en;
	assign result.valid  = vld_q[VLEN-1];
	assign result.result_bits = y_chain[NEWTON_STEPS];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[VLEN-2:0], operand.valid};
		end
	end

	// Integer first guess, with the sign bit kept by the arithmetic shift.
	assign seed = MAGIC_SEED - {operand.value_bits[31], operand.value_bits[31:1]};

	always_ff @(posedge clk) begin
		if (en) begin
			seed_s1 <= seed;
			seed_s2 <= seed_s1;
		end
	end

	// h = x * 0.5 runs alongside the seed delay.
	fisr_fmul u_half (.clk(clk), .en(en), .a(operand.value_bits), .b(HALF_BITS),
		.p(h_chain[0]));
	assign y_chain[0] = seed_s2;

	for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
		fisr_step u_step (
			.clk(clk), .en(en),
			.h_in(h_chain[k]), .y_in(y_chain[k]),
			.h_out(h_chain[k+1]), .y_out(y_chain[k+1])
		);
	end
endmodule

// File: hdl/fisr_checker.sv
module fisr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_bits
);
	import fisr_pkg::*;

	// A stalled result word holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bits))
		else $error("result word changed while stalled");

	// With no pending result the block must take operands.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("operand stalled with empty output");

	// A NaN result is always the canonical quiet NaN.
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_bits[30:23] == 8'hff && out_bits[22:0] != 23'd0
		|-> out_bits == CANON_NAN)
		else $error("non-canonical NaN");

	// No result word appears right after reset.
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result valid after reset");
endmodule

bind fast_inverse_sqrt_float32 fisr_checker u_fisr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (operand.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_bits  (result.result_bits)
);

// File: tb/tb_fast_inverse_sqrt_float32.sv
// Holds the words still owed by the block and predicts each one from its operand.
class rsqrt_scoreboard #(int STEPS = 1);
	logic [31:0] owed_q[$];
	int          mismatches;
	int          checked;

	function new();
		mismatches = 0;
		checked    = 0;
	endfunction

	static function automatic bit is_nan(logic [31:0] a);
		return a[30:23] == 8'hff && a[22:0] != 0;
	endfunction

	static function automatic bit is_inf(logic [31:0] a);
		return a[30:23] == 8'hff && a[22:0] == 0;
	endfunction

	static function automatic bit is_zero(logic [31:0] a);
		return a[30:0] == 0;
	endfunction

	// Splits a finite nonzero value into an integer significand and the weight of its lsb.
	static function automatic void unpack(input logic [31:0] a, output logic [127:0] m,
			output int e);
		if (a[30:23] == 0) begin
			m = {105'b0, a[22:0]};
			e = -149;
		end else begin
			m = {104'b0, 1'b1, a[22:0]};
			e = int'(a[30:23]) - 150;
		end
	endfunction

	// Rounds the exact value m * 2^e to single precision, nearest even, with subnormals.
	static function automatic logic [31:0] round_exact(logic s, logic [127:0] m, int e);
		int           msb;
		int           sh;
		int           ex;
		logic [255:0] w;
		logic [127:0] kept;
		logic         grd;
		logic         stk;
		if (m == 0) return {s, 31'b0};
		msb = 0;
		for (int i = 0; i < 128; i++) if (m[i]) msb = i;
		sh = msb - 23;
		if (sh < -149 - e) sh = -149 - e;
		if (sh <= 0) begin
			kept = m << (-sh);
			grd  = 1'b0;
			stk  = 1'b0;
		end else if (sh > 200) begin
			kept = '0;
			grd  = 1'b0;
			stk  = 1'b1;
		end else begin
			w    = {m, 128'b0} >> sh;
			kept = w[255:128];
			grd  = w[127];
			stk  = |w[126:0];
		end
		if (grd && (stk || kept[0])) kept = kept + 1;
		ex = e + sh;
		if (kept[24]) begin
			kept = kept >> 1;
			ex++;
		end
		if (!kept[23]) return {s, 8'h00, kept[22:0]};
		ex = ex + 150;
		if (ex >= 255) return {s, 8'hff, 23'b0};
		return {s, ex[7:0], kept[22:0]};
	endfunction

	static function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
		logic         s;
		logic [127:0] ma;
		logic [127:0] mb;
		int           ea;
		int           eb;
		s = a[31] ^ b[31];
		if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_NAN;
		if (is_inf(a) || is_inf(b)) begin
			if (is_zero(a) || is_zero(b)) return fisr_pkg::CANON_NAN;
			return {s, 8'hff, 23'b0};
		end
		if (is_zero(a) || is_zero(b)) return {s, 31'b0};
		unpack(a, ma, ea);
		unpack(b, mb, eb);
		return round_exact(s, ma * mb, ea + eb);
	endfunction

	static function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
		logic [127:0] ma;
		logic [127:0] mb;
		logic [127:0] tm;
		logic [31:0]  tb;
		int           ea;
		int           eb;
		int           d;
		if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_NAN;
		if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? fisr_pkg::CANON_NAN : a;
		if (is_inf(a)) return a;
		if (is_inf(b)) return b;
		if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'b0};
		if (is_zero(a)) return b;
		if (is_zero(b)) return a;
		unpack(a, ma, ea);
		unpack(b, mb, eb);
		// Keep the operand with the coarser lsb in a.
		if (ea < eb) begin
			tm = ma; ma = mb; mb = tm;
			d  = ea; ea = eb; eb = d;
			tb = a;  a  = b;  b  = tb;
		end
		d = ea - eb;
		// A far smaller operand only matters as a sticky bit.
		if (d > 100) begin
			ma = ma << 100;
			mb = 128'd1;
			eb = ea - 100;
		end else begin
			ma = ma << d;
		end
		if (a[31] == b[31]) return round_exact(a[31], ma + mb, eb);
		if (ma > mb) return round_exact(a[31], ma - mb, eb);
		if (mb > ma) return round_exact(b[31], mb - ma, eb);
		return 32'h0;
	endfunction

	// Integer seed followed by the Newton refinement steps.
	static function automatic logic [31:0] rsqrt_word(logic [31:0] x);
		logic [31:0] h;
		logic [31:0] y;
		logic [31:0] t;
		h = fmul(x, fisr_pkg::HALF_BITS);
		y = fisr_pkg::MAGIC_SEED - {x[31], x[31:1]};
		for (int k = 0; k < STEPS; k++) begin
			t = fmul(fmul(h, y), y);
			t = fadd(fisr_pkg::ONE_P5, t ^ 32'h80000000);
			y = fmul(y, t);
		end
		if (is_nan(y)) return fisr_pkg::CANON_NAN;
		return y;
	endfunction

	function void note_operand(logic [31:0] x);
		owed_q.push_back(rsqrt_word(x));
	endfunction

	function void check_result(logic [31:0] got);
		logic [31:0] want;
		if (owed_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("ERROR: result word %h with none owed", got);
			return;
		end
		want = owed_q.pop_front();
		checked++;
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: result_bits expected %h, got %h", want, got);
		end
	endfunction

	function int owed();
		return owed_q.size();
	endfunction
endclass

module tb_fast_inverse_sqrt_float32;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS      = 1;
	localparam int LATENCY    = 2 + 8 * STEPS;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_WORDS = 180;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   quiet_cycles;
	int   sent;

	fisr_in_if  operand_if();
	fisr_out_if result_if();

	rsqrt_scoreboard #(STEPS) sb;

	fast_inverse_sqrt_float32 #(.NEWTON_STEPS(STEPS)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand_if),
		.result (result_if)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Receiver back-pressure, changed on the falling edge.
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Accepted words on both sides, and the stall watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (operand_if.valid && operand_if.ready) sb.note_operand(operand_if.value_bits);
			if (result_if.valid && result_if.ready) sb.check_result(result_if.result_bits);
			if ((operand_if.valid && operand_if.ready) || (result_if.valid && result_if.ready))
				quiet_cycles = 0;
			else if (operand_if.valid || sb.owed() != 0)
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_word(logic [31:0] x);
		while ($urandom_range(99) < send_idle_pct) begin
			operand_if.valid = 1'b0;
			@(negedge clk);
		end
		operand_if.valid      = 1'b1;
		operand_if.value_bits = x;
		do @(posedge clk); while (!operand_if.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic wait_drained();
		operand_if.valid = 1'b0;
		while (sb.owed() != 0) @(negedge clk);
	endtask

	// Half plausible positive operands, plus exponent edges and raw noise.
	function automatic logic [31:0] random_operand();
		logic [7:0] ex;
		case ($urandom_range(9))
			0, 1, 2: return $urandom();
			3: begin
				ex = ($urandom_range(1)) ? 8'h00 : 8'hff;
				return {1'($urandom_range(1)), ex, 23'($urandom())};
			end
			4: begin
				ex = ($urandom_range(1)) ? 8'($urandom_range(1, 3)) : 8'($urandom_range(252, 254));
				return {1'($urandom_range(1)), ex, 23'($urandom())};
			end
			default: begin
				ex = 8'($urandom_range(100, 154));
				return {1'b0, ex, 23'($urandom())};
			end
		endcase
	endfunction

	initial begin
		logic [31:0] directed[$];
		sb = new();
		sent = 0;
		quiet_cycles = 0;
		send_idle_pct = 22;
		recv_idle_pct = 78;
		operand_if.valid = 1'b0;
		operand_if.value_bits = '0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Zeros, infinities, NaNs, subnormal and normal limits, negatives, plain values.
		directed = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
			32'h7fc00000, 32'h7f800001, 32'hffffffff, 32'h00000001,
			32'h007fffff, 32'h00800000, 32'h7f7fffff, 32'hff7fffff,
			32'h80000001, 32'h3f800000, 32'h40800000, 32'h3e800000,
			32'hbf800000, 32'h3f000000, 32'h55555555, 32'haaaaaaaa,
			32'h5f3759df, 32'h7effffff, 32'h00400000};
		foreach (directed[i]) send_word(directed[i]);
		repeat (PHASE_WORDS - directed.size()) send_word(random_operand());

		// Hold the sender until everything in flight has come back.
		wait_drained();
		send_idle_pct = 78;
		recv_idle_pct = 22;
		repeat (PHASE_WORDS) send_word(random_operand());

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (PHASE_WORDS + 10) send_word(random_operand());

		wait_drained();
		repeat (LATENCY + 5) @(negedge clk);
		if (result_if.valid) begin
			sb.mismatches++;
			$display("ERROR: extra result word after the run drained");
		end
		if (sb.owed() != 0) begin
			sb.mismatches += sb.owed();
			$display("ERROR: %0d result words never arrived", sb.owed());
		end

		$display("Covered %0d operands (special values, subnormals, negatives, random) over",
			sent);
		$display("three stall profiles; %0d results checked, %0d mismatches.", sb.checked,
			sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// File: sim.f
hdl/fisr_pkg.sv
hdl/fisr_in_if.sv
hdl/fisr_out_if.sv
hdl/fisr_fmul.sv
hdl/fisr_fsub.sv
hdl/fisr_step.sv
hdl/fast_inverse_sqrt_float32.sv
hdl/fisr_checker.sv
tb/tb_fast_inverse_sqrt_float32.sv
